>>> rtl/ampq_pkg.sv
// Package for the array max priority queue: payload structs, operation and
// status codes, and the controller/datapath command and status bundles.
// No dependencies.
package ampq_pkg;

    // Default number of stored entries
    localparam int DEPTH_DEF = 8;

    // Operation codes (kind field)
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_PEEK   = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // Input beat
    typedef struct packed {
        logic [1:0]          kind;
        logic signed [31:0]  value;
    } t_in;

    // Output beat
    typedef struct packed {
        logic signed [31:0]  result_value;
        logic [1:0]          status;
        logic [3:0]          occupancy;
    } t_out;

    // Controller to datapath commands
    typedef struct packed {
        logic exec_now;    // finish an operation on the input beat that needs no search
        logic scan_start;  // load entry 0 as the running maximum
        logic scan_step;   // compare one more entry
        logic commit;      // remove the maximum, close the gap, emit result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic needs_scan;  // input beat is a remove on a non-empty queue
        logic scan_done;   // every stored entry has been compared
    } t_sts;

endpackage

>>> rtl/ampq_ctrl.sv
// Controller for the array max priority queue: handshake and sequencing of
// the maximum search. Depends on ampq_pkg.
module ampq_ctrl
    import ampq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;
    logic   w_accept;

    // Output register can take a new beat this cycle
    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = !((r_state == S_IDLE) && w_out_free);
    assign w_accept   = i_valid && !o_stall;
    assign o_valid    = r_out_valid;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_stall;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_sts.needs_scan) begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end else begin
                        o_cmd.exec_now = 1'b1;
                        n_out_valid    = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (!i_sts.scan_done) begin
                    o_cmd.scan_step = 1'b1;
                end else if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> rtl/ampq_dp.sv
// Datapath for the array max priority queue: entry registers, fill count,
// running-maximum search and the output register. Depends on ampq_pkg.
module ampq_dp
    import ampq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_in,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output t_out o_out
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic signed [31:0] r_entries [DEPTH];
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_idx;
    logic [IW-1:0]      r_pos;
    logic signed [31:0] r_best;
    t_out               r_out;

    logic signed [31:0] w_rd;
    logic [CW-1:0]      w_count_dec;
    logic [CW-1:0]      w_count_inc;
    logic               w_empty;
    logic               w_full;

    // Occupancy is the count masked to four bits
    function automatic logic [3:0] occ(input logic [CW-1:0] c);
        logic [CW+3:0] wide;
        wide = {4'b0000, c};
        return wide[3:0];
    endfunction

    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count == CW'(DEPTH));
    assign w_count_dec = r_count - CW'(1);
    assign w_count_inc = r_count + CW'(1);
    assign w_rd        = r_entries[r_idx[IW-1:0]];

    assign o_sts.needs_scan = (i_in.kind == KIND_REMOVE) && !w_empty;
    assign o_sts.scan_done  = (r_idx >= r_count);
    assign o_out            = r_out;

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec_now && i_in.kind == KIND_INSERT && !w_full) begin
            r_count <= w_count_inc;
        end else if (i_cmd.commit) begin
            r_count <= w_count_dec;
        end
    end

    // Entries, search registers and output beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec_now) begin
            case (i_in.kind)
                KIND_INSERT: begin
                    r_out.result_value <= '0;
                    if (w_full) begin
                        r_out.status    <= ST_OVERFLOW;
                        r_out.occupancy <= occ(r_count);
                    end else begin
                        r_entries[r_count[IW-1:0]] <= i_in.value;
                        r_out.status               <= ST_OK;
                        r_out.occupancy            <= occ(w_count_inc);
                    end
                end
                KIND_REMOVE: begin
                    // only reached here when empty
                    r_out.result_value <= '0;
                    r_out.status       <= ST_UNDERFLOW;
                    r_out.occupancy    <= occ(r_count);
                end
                KIND_PEEK: begin
                    r_out.occupancy <= occ(r_count);
                    if (w_empty) begin
                        r_out.result_value <= '0;
                        r_out.status       <= ST_UNDERFLOW;
                    end else begin
                        r_out.result_value <= r_entries[0];
                        r_out.status       <= ST_OK;
                    end
                end
                default: begin
                    r_out.result_value <= '0;
                    r_out.status       <= ST_OK;
                    r_out.occupancy    <= occ(r_count);
                end
            endcase
        end

        // Start of search: entry 0 is the first candidate
        if (i_cmd.scan_start) begin
            r_best <= r_entries[0];
            r_pos  <= '0;
            r_idx  <= CW'(1);
        end

        // One compare per cycle; strict greater keeps the earliest on ties
        if (i_cmd.scan_step) begin
            if (w_rd > r_best) begin
                r_best <= w_rd;
                r_pos  <= r_idx[IW-1:0];
            end
            r_idx <= r_idx + CW'(1);
        end

        // Remove the maximum and shift later entries down one place
        if (i_cmd.commit) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                if (IW'(i) >= r_pos) begin
                    r_entries[i] <= r_entries[i+1];
                end
            end
            r_out.result_value <= r_best;
            r_out.status       <= ST_OK;
            r_out.occupancy    <= occ(w_count_dec);
        end
    end

endmodule

>>> rtl/array_max_priority_queue_unit.sv
// Array max priority queue, top level: joins the controller and datapath.
// Depends on ampq_pkg, ampq_ctrl and ampq_dp.
//
// Bounded queue of up to DEPTH signed 32-bit values held in arrival order.
// Each input beat (insert, remove largest, peek oldest) yields exactly one
// output beat carrying the value, a status (ok, overflow, underflow) and
// the occupancy after the operation. Insert, peek, failing operations and
// the unused kind finish without a search: a new beat can be accepted every
// cycle while the output side keeps up. A remove on a non-empty queue
// walks the entries with a single comparator, one entry per cycle, then
// closes the gap once the output register is free, and only then is the
// next beat accepted. The output register holds one result; while that
// result is stalled the input is stalled too, and a new beat is accepted
// in the same cycle the held result is taken.
module array_max_priority_queue_unit
    import ampq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_in,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_out
);

    t_cmd w_cmd;
    t_sts w_sts;

    ampq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    ampq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_out   (o_out)
    );

endmodule
